FILE: hw/rtl/aps_pkg.sv
`default_nettype none

package aps_pkg;

	localparam int DEPTH  = 64;
	localparam int ACT_W  = 2;
	localparam int TIME_W = 31;
	localparam int SEV_W  = 31;
	localparam int RATE_W = 31;
	localparam int ID_W   = 64;
	localparam int KEY_W  = 64;
	localparam int PROD_W = TIME_W + RATE_W;
	localparam int STAT_W = 2;
	localparam int OP_W   = 3;

	localparam logic [ACT_W-1:0] ACT_ARRIVE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SERVE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LEAVE  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_SERVED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

	localparam logic [OP_W-1:0] OP_HOLD   = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OP_W-1:0] OP_POP    = 3'd2;
	localparam logic [OP_W-1:0] OP_DROP   = 3'd3;
	localparam logic [OP_W-1:0] OP_SETTLE = 3'd4;

	typedef struct packed {
		logic            valid;
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  ident;
	} entry_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		entry_t          item;
	} cell_cmd_t;

	function automatic logic better(entry_t a, entry_t b);
		logic gt;
		logic tie;
		gt  = $signed(a.key) > $signed(b.key);
		tie = (a.key == b.key) && (a.ident < b.ident);
		return gt || tie;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/aps_req_if.sv
`default_nettype none

interface aps_req_if;

	logic                      valid;
	logic                      ready;
	logic [aps_pkg::ACT_W-1:0]  action;
	logic [aps_pkg::TIME_W-1:0] arrival_time;
	logic [aps_pkg::ID_W-1:0]   request_id;
	logic [aps_pkg::SEV_W-1:0]  severity;

	modport source (
		output valid, action, arrival_time, request_id, severity,
		input  ready
	);

	modport sink (
		input  valid, action, arrival_time, request_id, severity,
		output ready
	);

endinterface

`default_nettype wire

FILE: hw/rtl/aps_rsp_if.sv
`default_nettype none

interface aps_rsp_if;

	logic                      valid;
	logic                      ready;
	logic [aps_pkg::STAT_W-1:0] status;
	logic [aps_pkg::ID_W-1:0]   served_id;

	modport source (
		output valid, status, served_id,
		input  ready
	);

	modport sink (
		input  valid, status, served_id,
		output ready
	);

endinterface

`default_nettype wire

FILE: hw/rtl/aps_cell.sv
`default_nettype none

module aps_cell (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire aps_pkg::cell_cmd_t cmd,
	input  wire                logic lower,
	input  wire aps_pkg::entry_t    prev,
	input  wire                logic prev_ins,
	input  wire aps_pkg::entry_t    next,
	output aps_pkg::entry_t    cur,
	output logic               ins
);

	logic                      valid_q;
	logic [aps_pkg::KEY_W-1:0] key_q;
	logic [aps_pkg::ID_W-1:0]  ident_q;
	aps_pkg::entry_t           nxt;

	assign cur = '{valid: valid_q, key: key_q, ident: ident_q};
	assign ins = !valid_q || aps_pkg::better(cmd.item, cur);

	always_comb begin
		nxt = cur;
		unique case (cmd.op)
			aps_pkg::OP_INSERT: begin
				if (prev_ins) begin
					nxt = prev;
				end else if (ins) begin
					nxt = cmd.item;
				end
			end
			aps_pkg::OP_POP: begin
				nxt = next;
			end
			aps_pkg::OP_DROP: begin
				if (cur.valid && cur.ident == cmd.item.ident) begin
					nxt.valid = 1'b0;
				end
			end
			aps_pkg::OP_SETTLE: begin
				// swap a hole toward the tail
				if (lower && !cur.valid && next.valid) begin
					nxt = next;
				end else if (!lower && !prev.valid && cur.valid) begin
					nxt.valid = 1'b0;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		key_q   <= nxt.key;
		ident_q <= nxt.ident;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/aging_priority_queue_scheduler_core.sv
// Priority queue of up to 64 requests kept as a sorted row of cells, best key
// (severity - arrival_time * aging_rate, signed 64 bit; smaller id on equal
// keys) at the head. Words are taken on req when the block is idle; arrive and
// serve first register the aging product, then the exec state broadcasts the
// key to every cell and shifts the row by one place. Leave clears the matching
// entry and holds off the next word until the row has closed its holes:
// neighboring cells swap a hole one place per cycle in alternating odd and even
// pairs. Results go to a registered rsp word; the next request word is taken
// while a result still waits. aging_rate is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle, which the block does
// not enforce. Valid marks clear at reset; there is no clearing pass.
`default_nettype none

module aging_priority_queue_scheduler_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	aps_req_if.sink                          req,
	aps_rsp_if.source                        rsp,
	input  wire logic                        cfg_we,
	input  wire logic [aps_pkg::RATE_W-1:0]  cfg_wdata
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;
	localparam aps_pkg::entry_t HEAD_GUARD = '{valid: 1'b1, key: '0, ident: '0};
	localparam aps_pkg::entry_t TAIL_GUARD = '{valid: 1'b0, key: '0, ident: '0};

	logic                         state_q;
	logic                         phase_q;
	logic [aps_pkg::RATE_W-1:0]   rate_q;
	logic [aps_pkg::ACT_W-1:0]    action_s1;
	logic [aps_pkg::SEV_W-1:0]    sev_s1;
	logic [aps_pkg::ID_W-1:0]     ident_s1;
	logic [aps_pkg::PROD_W-1:0]   prod_s1;
	logic                         rsp_valid_q;
	logic [aps_pkg::STAT_W-1:0]   status_q;
	logic [aps_pkg::ID_W-1:0]     served_q;

	aps_pkg::entry_t              chain [aps_pkg::DEPTH];
	logic [aps_pkg::DEPTH-1:0]    ins_vec;
	logic [aps_pkg::DEPTH-2:0]    hole_vec;
	aps_pkg::cell_cmd_t           cmd;

	logic unsorted;
	logic full;
	logic empty;
	logic need_result;
	logic exec_go;
	logic fire;
	logic accept;
	logic [aps_pkg::STAT_W-1:0] res_status;
	logic [aps_pkg::ID_W-1:0]   res_id;

	assign unsorted = |hole_vec;
	assign full     = chain[aps_pkg::DEPTH-1].valid;
	assign empty    = !chain[0].valid;

	assign req.ready = (state_q == ST_IDLE) && !unsorted;
	assign accept    = req.valid && req.ready;

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.served_id = served_q;

	always_comb begin
		need_result = 1'b0;
		res_status  = aps_pkg::STAT_SERVED;
		res_id      = '0;
		unique case (action_s1)
			aps_pkg::ACT_ARRIVE: begin
				need_result = full;
				res_status  = aps_pkg::STAT_FULL;
			end
			aps_pkg::ACT_SERVE: begin
				need_result = 1'b1;
				if (empty) begin
					res_status = aps_pkg::STAT_EMPTY;
				end else begin
					res_id = chain[0].ident;
				end
			end
			default: begin
				need_result = 1'b0;
			end
		endcase
	end

	assign exec_go = !(need_result && rsp_valid_q && !rsp.ready);
	assign fire    = (state_q == ST_EXEC) && exec_go && need_result;

	always_comb begin
		cmd.item.valid = 1'b1;
		cmd.item.key   = aps_pkg::KEY_W'(sev_s1) - aps_pkg::KEY_W'(prod_s1);
		cmd.item.ident = ident_s1;
		cmd.op         = aps_pkg::OP_HOLD;
		if (state_q == ST_IDLE) begin
			cmd.op = aps_pkg::OP_SETTLE;
		end else if (exec_go) begin
			unique case (action_s1)
				aps_pkg::ACT_ARRIVE: cmd.op = full ? aps_pkg::OP_HOLD : aps_pkg::OP_INSERT;
				aps_pkg::ACT_SERVE:  cmd.op = empty ? aps_pkg::OP_HOLD : aps_pkg::OP_POP;
				aps_pkg::ACT_LEAVE:  cmd.op = aps_pkg::OP_DROP;
				default:             cmd.op = aps_pkg::OP_HOLD;
			endcase
		end
	end

	for (genvar i = 0; i < aps_pkg::DEPTH; i++) begin : g_cell
		localparam logic ODD = (i % 2) == 1;
		aps_pkg::entry_t prev_e;
		aps_pkg::entry_t next_e;
		logic            prev_i;

		if (i == 0) begin : g_head
			assign prev_e = HEAD_GUARD;
			assign prev_i = 1'b0;
		end else begin : g_body
			assign prev_e = chain[i-1];
			assign prev_i = ins_vec[i-1];
		end

		if (i == aps_pkg::DEPTH - 1) begin : g_tail
			assign next_e = TAIL_GUARD;
		end else begin : g_link
			assign next_e = chain[i+1];
			assign hole_vec[i] = !chain[i].valid && chain[i+1].valid;
		end

		aps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.lower    (ODD == phase_q),
			.prev     (prev_e),
			.prev_ins (prev_i),
			.next     (next_e),
			.cur      (chain[i]),
			.ins      (ins_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			rate_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_wdata;
			end
			if (state_q == ST_IDLE) begin
				phase_q <= !phase_q;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= req.action;
			sev_s1    <= req.severity;
			ident_s1  <= req.request_id;
			prod_s1   <= aps_pkg::PROD_W'(req.arrival_time) * aps_pkg::PROD_W'(rate_q);
		end
		if (fire) begin
			status_q <= res_status;
			served_q <= res_id;
		end
	end

	a_no_insert_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == aps_pkg::OP_INSERT |-> !full)
		else $error("insert issued into a full row");

	a_result_registered: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("result lost");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(req.ready && chain[1].valid) |-> !aps_pkg::better(chain[1], chain[0]))
		else $error("row head out of order");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |-> !fire)
		else $error("waiting result overwritten");

endmodule

`default_nettype wire
